>>> design/tmas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmas_pkg
// Shared constants, types and constant tables of the trimmed mean ADC scaler.
// ----------------------------------------------------------------------------
package tmas_pkg;

    localparam int WINDOW_SIZE = 10;

    localparam int SAMPLE_W  = 13;
    localparam int MEAN_W    = 13;
    localparam int MV_W      = 14;
    localparam int IDX_W     = $clog2(WINDOW_SIZE);
    localparam int CNT_W     = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W     = $clog2(WINDOW_SIZE * (2 ** SAMPLE_W));
    localparam int VAL_W     = 25;
    localparam int RECIP_W   = VAL_W + 1;
    localparam int PROD_W    = VAL_W + RECIP_W;
    localparam int MULT_W    = 12;
    localparam int DIV_W     = 13;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam int TRIM_DIV    = WINDOW_SIZE - 2;
    localparam int SCALE_NUM_A = 2563;
    localparam int SCALE_DEN_A = 8191;
    localparam int SCALE_NUM_B = 321;
    localparam int SCALE_DEN_B = 51;
    localparam int MEAN_MAX    = 8191;
    localparam int MV_MAX      = 16131;

    // floor(2^VAL_W / d): quotient estimate is exact or one low
    localparam longint RECIP_TRIM = (64'd1 << VAL_W) / TRIM_DIV;
    localparam longint RECIP_A    = (64'd1 << VAL_W) / SCALE_DEN_A;
    localparam longint RECIP_B    = (64'd1 << VAL_W) / SCALE_DEN_B;

    typedef enum logic [2:0] {
        ARITH_NOP,
        ARITH_LOAD,
        ARITH_MUL,
        ARITH_RECIP,
        ARITH_CORR
    } arith_op_t;

    typedef enum logic [1:0] {
        CSEL_TRIM,
        CSEL_A,
        CSEL_B
    } csel_t;

    typedef struct packed {
        arith_op_t         op;
        csel_t             csel;
        logic [VAL_W-1:0]  load_val;
    } arith_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_DIVT_R,
        ST_DIVT_C,
        ST_MULA,
        ST_DIVA_R,
        ST_DIVA_C,
        ST_MULB,
        ST_DIVB_R,
        ST_DIVB_C,
        ST_DONE
    } state_t;

    function automatic logic [DIV_W-1:0] csel_div(input csel_t csel);
        logic [DIV_W-1:0] d;
        case (csel)
            CSEL_TRIM: d = DIV_W'(TRIM_DIV);
            CSEL_A:    d = DIV_W'(SCALE_DEN_A);
            CSEL_B:    d = DIV_W'(SCALE_DEN_B);
            default:   d = DIV_W'(1);
        endcase
        return d;
    endfunction

    function automatic logic [RECIP_W-1:0] csel_recip(input csel_t csel);
        logic [RECIP_W-1:0] r;
        case (csel)
            CSEL_TRIM: r = RECIP_W'(RECIP_TRIM);
            CSEL_A:    r = RECIP_W'(RECIP_A);
            CSEL_B:    r = RECIP_W'(RECIP_B);
            default:   r = RECIP_W'(1);
        endcase
        return r;
    endfunction

    function automatic logic [MULT_W-1:0] csel_mult(input csel_t csel);
        logic [MULT_W-1:0] m;
        case (csel)
            CSEL_A:  m = MULT_W'(SCALE_NUM_A);
            CSEL_B:  m = MULT_W'(SCALE_NUM_B);
            default: m = MULT_W'(1);
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

>>> design/tmas_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmas_ring
// Sample ring memory: one write port, one registered read port, and a valid
// bit per entry so that entries not yet written read as zero.
// ----------------------------------------------------------------------------
module tmas_ring (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [tmas_pkg::IDX_W-1:0]    wr_addr,
    input  wire logic [tmas_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [tmas_pkg::IDX_W-1:0]    rd_addr,
    output logic      [tmas_pkg::SAMPLE_W-1:0] rd_data
);

    logic [tmas_pkg::SAMPLE_W-1:0] mem [tmas_pkg::WINDOW_SIZE];
    logic [tmas_pkg::WINDOW_SIZE-1:0] valid_reg;
    logic [tmas_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

>>> design/tmas_arith.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmas_arith
// Shared multiply and divide-by-constant unit. Division is a reciprocal
// multiply followed by a one-step remainder correction.
// ----------------------------------------------------------------------------
module tmas_arith (
    input  wire logic                       aclk,
    input  wire tmas_pkg::arith_ctl_t       ctl,
    output logic      [tmas_pkg::VAL_W-1:0] val
);

    logic [tmas_pkg::VAL_W-1:0]  val_reg, val_next;
    logic [tmas_pkg::PROD_W-1:0] prod_reg, prod_next;

    logic [tmas_pkg::DIV_W-1:0]   div_c;
    logic [tmas_pkg::RECIP_W-1:0] recip_c;
    logic [tmas_pkg::MULT_W-1:0]  mult_c;

    logic [tmas_pkg::VAL_W+tmas_pkg::MULT_W-1:0] mul_full;
    logic [tmas_pkg::VAL_W-1:0]                  quot_est;
    logic [tmas_pkg::VAL_W+tmas_pkg::DIV_W-1:0]  back_full;
    logic [tmas_pkg::VAL_W-1:0]                  rem;

    always_comb begin
        div_c     = tmas_pkg::csel_div(ctl.csel);
        recip_c   = tmas_pkg::csel_recip(ctl.csel);
        mult_c    = tmas_pkg::csel_mult(ctl.csel);
        mul_full  = val_reg * mult_c;
        quot_est  = prod_reg[2*tmas_pkg::VAL_W-1:tmas_pkg::VAL_W];
        back_full = quot_est * div_c;
        // estimate is never above the true quotient, so rem stays below 2*d
        rem       = val_reg - back_full[tmas_pkg::VAL_W-1:0];

        val_next  = val_reg;
        prod_next = prod_reg;
        case (ctl.op)
            tmas_pkg::ARITH_LOAD:  val_next  = ctl.load_val;
            tmas_pkg::ARITH_MUL:   val_next  = mul_full[tmas_pkg::VAL_W-1:0];
            tmas_pkg::ARITH_RECIP: prod_next = val_reg * recip_c;
            tmas_pkg::ARITH_CORR: begin
                val_next = quot_est
                         + tmas_pkg::VAL_W'(rem >= tmas_pkg::VAL_W'(div_c));
            end
            default: begin
                val_next  = val_reg;
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        prod_reg <= prod_next;
    end

    assign val = val_reg;

endmodule
`default_nettype wire

>>> design/trimmed_mean_adc_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trimmed_mean_adc_scaler
// Trimmed mean of the last WINDOW_SIZE ADC samples, scaled to millivolts.
// ----------------------------------------------------------------------------
// Each accepted sample word is written into a ring of the last WINDOW_SIZE
// samples (zero after reset), then the ring is read back one entry a cycle
// to form the sum, maximum and minimum. The trimmed mean and the millivolt
// value follow from a shared multiply / constant-divide unit, which runs
// nine arithmetic steps after the one-entry-per-cycle ring read; a new
// sample is taken once the previous result has moved into the output
// register, which may still be waiting on m_tready.
module trimmed_mean_adc_scaler (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tmas_pkg::S_TDATA_W-1:0] s_tdata,  // sample[12:0], zero pad
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [tmas_pkg::M_TDATA_W-1:0] m_tdata   // trimmed_mean[12:0],
                                                          // millivolts[26:13], zero pad
);

    tmas_pkg::state_t state_reg, state_next;

    logic [tmas_pkg::IDX_W-1:0]    slot_reg, slot_next;
    logic [tmas_pkg::CNT_W-1:0]    scan_cnt_reg, scan_cnt_next;
    logic                          pend_reg, pend_next;
    logic [tmas_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [tmas_pkg::SAMPLE_W-1:0] hi_reg, hi_next;
    logic [tmas_pkg::SAMPLE_W-1:0] lo_reg, lo_next;
    logic [tmas_pkg::MEAN_W-1:0]   mean_reg, mean_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [tmas_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                          accept;
    logic                          scan_done;
    logic                          out_free;
    logic                          rd_en;
    logic [tmas_pkg::SAMPLE_W-1:0] rd_data;
    tmas_pkg::arith_ctl_t          arith_ctl;
    logic [tmas_pkg::VAL_W-1:0]    arith_val;

    tmas_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept),
        .wr_addr (slot_reg),
        .wr_data (s_tdata[tmas_pkg::SAMPLE_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (scan_cnt_reg[tmas_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    tmas_arith u_arith (
        .aclk (aclk),
        .ctl  (arith_ctl),
        .val  (arith_val)
    );

    assign accept    = s_tvalid && s_tready;
    assign scan_done = (scan_cnt_reg == tmas_pkg::CNT_W'(tmas_pkg::WINDOW_SIZE)) && !pend_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tmas_pkg::ST_IDLE:   if (s_tvalid) state_next = tmas_pkg::ST_SCAN;
            tmas_pkg::ST_SCAN:   if (scan_done) state_next = tmas_pkg::ST_LOAD;
            tmas_pkg::ST_LOAD:   state_next = tmas_pkg::ST_DIVT_R;
            tmas_pkg::ST_DIVT_R: state_next = tmas_pkg::ST_DIVT_C;
            tmas_pkg::ST_DIVT_C: state_next = tmas_pkg::ST_MULA;
            tmas_pkg::ST_MULA:   state_next = tmas_pkg::ST_DIVA_R;
            tmas_pkg::ST_DIVA_R: state_next = tmas_pkg::ST_DIVA_C;
            tmas_pkg::ST_DIVA_C: state_next = tmas_pkg::ST_MULB;
            tmas_pkg::ST_MULB:   state_next = tmas_pkg::ST_DIVB_R;
            tmas_pkg::ST_DIVB_R: state_next = tmas_pkg::ST_DIVB_C;
            tmas_pkg::ST_DIVB_C: state_next = tmas_pkg::ST_DONE;
            tmas_pkg::ST_DONE:   if (out_free) state_next = tmas_pkg::ST_IDLE;
            default:             state_next = tmas_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready           = 1'b0;
        rd_en              = 1'b0;
        arith_ctl.op       = tmas_pkg::ARITH_NOP;
        arith_ctl.csel     = tmas_pkg::CSEL_TRIM;
        arith_ctl.load_val = tmas_pkg::VAL_W'(sum_reg)
                           - tmas_pkg::VAL_W'(hi_reg) - tmas_pkg::VAL_W'(lo_reg);
        case (state_reg)
            tmas_pkg::ST_IDLE: s_tready = 1'b1;
            tmas_pkg::ST_SCAN: begin
                rd_en = scan_cnt_reg < tmas_pkg::CNT_W'(tmas_pkg::WINDOW_SIZE);
            end
            tmas_pkg::ST_LOAD:   arith_ctl.op = tmas_pkg::ARITH_LOAD;
            tmas_pkg::ST_DIVT_R: arith_ctl.op = tmas_pkg::ARITH_RECIP;
            tmas_pkg::ST_DIVT_C: arith_ctl.op = tmas_pkg::ARITH_CORR;
            tmas_pkg::ST_MULA: begin
                arith_ctl.op   = tmas_pkg::ARITH_MUL;
                arith_ctl.csel = tmas_pkg::CSEL_A;
            end
            tmas_pkg::ST_DIVA_R: begin
                arith_ctl.op   = tmas_pkg::ARITH_RECIP;
                arith_ctl.csel = tmas_pkg::CSEL_A;
            end
            tmas_pkg::ST_DIVA_C: begin
                arith_ctl.op   = tmas_pkg::ARITH_CORR;
                arith_ctl.csel = tmas_pkg::CSEL_A;
            end
            tmas_pkg::ST_MULB: begin
                arith_ctl.op   = tmas_pkg::ARITH_MUL;
                arith_ctl.csel = tmas_pkg::CSEL_B;
            end
            tmas_pkg::ST_DIVB_R: begin
                arith_ctl.op   = tmas_pkg::ARITH_RECIP;
                arith_ctl.csel = tmas_pkg::CSEL_B;
            end
            tmas_pkg::ST_DIVB_C: begin
                arith_ctl.op   = tmas_pkg::ARITH_CORR;
                arith_ctl.csel = tmas_pkg::CSEL_B;
            end
            default: begin
                s_tready = 1'b0;
                rd_en    = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        slot_next     = slot_reg;
        scan_cnt_next = scan_cnt_reg;
        pend_next     = rd_en;
        sum_next      = sum_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        mean_next     = mean_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (accept) begin
            slot_next = (slot_reg == tmas_pkg::IDX_W'(tmas_pkg::WINDOW_SIZE - 1))
                      ? '0 : slot_reg + 1'b1;
            scan_cnt_next = '0;
            sum_next      = '0;
            hi_next       = '0;
            lo_next       = '1;
        end
        if (rd_en) begin
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end
        // read word lands in the cycle after its address
        if (pend_reg) begin
            sum_next = sum_reg + tmas_pkg::SUM_W'(rd_data);
            if (rd_data > hi_reg) hi_next = rd_data;
            if (rd_data < lo_reg) lo_next = rd_data;
        end
        if (state_reg == tmas_pkg::ST_MULA) begin
            mean_next = arith_val[tmas_pkg::MEAN_W-1:0];
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (state_reg == tmas_pkg::ST_DONE && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = tmas_pkg::M_TDATA_W'(
                {arith_val[tmas_pkg::MV_W-1:0], mean_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tmas_pkg::ST_IDLE;
            slot_reg     <= '0;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            scan_cnt_reg <= scan_cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg     <= sum_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        mean_reg    <= mean_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == tmas_pkg::ST_SCAN))
        else $error("accepted word did not start a ring scan");

    a_scan_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_cnt_reg <= tmas_pkg::CNT_W'(tmas_pkg::WINDOW_SIZE))
        else $error("scan counter past window");

    a_pend_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == tmas_pkg::ST_SCAN))
        else $error("ring read pending outside scan");

    a_mean_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tmas_pkg::ST_MULA)
            |-> (arith_val <= tmas_pkg::VAL_W'(tmas_pkg::MEAN_MAX)))
        else $error("trimmed mean out of range");

    a_mv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tmas_pkg::ST_DONE)
            |-> (arith_val <= tmas_pkg::VAL_W'(tmas_pkg::MV_MAX)))
        else $error("millivolt value out of range");
`endif

endmodule
`default_nettype wire

>>> dv/trimmed_mean_adc_scaler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_adc_scaler_tb
// Self-checking bench for the trimmed mean ADC scaler.
// ----------------------------------------------------------------------------
// ADC codes are streamed in from a queue, first a handful of directed words
// (extremes, early results over a zeroed ring, repeated extremes), then
// random segments of flat, noisy, ramping and rail-to-rail codes. A local
// ring model predicts the trimmed mean and millivolt value of every accepted
// word and the monitor compares them with each result word. The sender
// bursts and gaps, the receiver stalls, and quiet stretches run without
// either.
module trimmed_mean_adc_scaler_tb;
    import tmas_pkg::*;

    typedef struct {
        logic [SAMPLE_W-1:0] code;
        bit                  drain_first;  // hold until all results are back
    } adc_word_t;

    typedef struct {
        logic [MEAN_W-1:0] mean;
        logic [MV_W-1:0]   mv;
    } reading_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    adc_word_t           adc_words[$];
    reading_t            pending_readings[$];
    logic [SAMPLE_W-1:0] adc_ring[WINDOW_SIZE] = '{default: '0};
    int                  ring_slot = 0;
    int                  mismatch_count = 0;
    logic                word_taken = 1'b0;
    int                  burst_left = 1;
    int                  gap_left = 0;
    int                  stall_left = 0;
    int                  calm_left = 0;

    trimmed_mean_adc_scaler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // sample[12:0], zero pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // trimmed_mean[12:0], millivolts[26:13], zero pad
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // writes the code into the ring, then trims one max and one min
    function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] code);
        reading_t    r;
        int unsigned total, top, bottom, mean_v, mv_v;
        adc_ring[ring_slot] = code;
        ring_slot = (ring_slot == WINDOW_SIZE - 1) ? 0 : ring_slot + 1;
        total = adc_ring[0];
        top = adc_ring[0];
        bottom = adc_ring[0];
        for (int k = 1; k < WINDOW_SIZE; k++) begin
            if (adc_ring[k] > top) top = adc_ring[k];
            if (adc_ring[k] < bottom) bottom = adc_ring[k];
            total += adc_ring[k];
        end
        mean_v = (total - top - bottom) / (WINDOW_SIZE - 2);
        mv_v = (mean_v * SCALE_NUM_A) / SCALE_DEN_A;
        mv_v = (mv_v * SCALE_NUM_B) / SCALE_DEN_B;
        r.mean = mean_v[MEAN_W-1:0];
        r.mv = mv_v[MV_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, wanted %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic queue_code(input int code, input bit drain_first = 1'b0);
        adc_word_t w;
        if (code < 0) code = 0;
        if (code > MEAN_MAX) code = MEAN_MAX;
        w.code = code[SAMPLE_W-1:0];
        w.drain_first = drain_first;
        adc_words.push_back(w);
    endtask

    // sender and receiver both move on the falling edge
    always @(negedge aclk) begin : stream_drive
        adc_word_t            w;
        logic                 next_valid;
        logic [S_TDATA_W-1:0] next_data;
        next_valid = s_tvalid;
        next_data = s_tdata;
        if (calm_left != 0) calm_left--;
        else if ($urandom_range(0, 1499) == 0) calm_left = $urandom_range(300, 2000);

        if (!aresetn) begin
            next_valid = 1'b0;
        end else if (s_tvalid && !word_taken) begin
            // word still waiting for s_tready
        end else begin
            next_valid = 1'b0;
            if (gap_left != 0 && calm_left == 0) begin
                gap_left--;
            end else if (adc_words.size() != 0 &&
                         !(adc_words[0].drain_first && pending_readings.size() != 0)) begin
                w = adc_words.pop_front();
                next_valid = 1'b1;
                next_data = S_TDATA_W'(w.code);
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 30);
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata <= next_data;

        if (stall_left != 0 && calm_left == 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = 0;
            m_tready <= 1'b1;
            if (calm_left == 0 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 25);
        end
    end

    always @(posedge aclk) begin : result_check
        reading_t got, want;
        word_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_readings.push_back(predict_reading(s_tdata[SAMPLE_W-1:0]));
            if (m_tvalid && m_tready) begin
                got.mean = m_tdata[MEAN_W-1:0];
                got.mv = m_tdata[MEAN_W+MV_W-1:MEAN_W];
                if (pending_readings.size() == 0) begin
                    note_mismatch("result word with nothing pending", got.mean, -1);
                end else begin
                    want = pending_readings.pop_front();
                    if (got.mean !== want.mean)
                        note_mismatch("trimmed_mean", got.mean, want.mean);
                    if (got.mv !== want.mv)
                        note_mismatch("millivolts", got.mv, want.mv);
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int seg_kind, seg_len, base, spread, step;
        // early results over a zeroed ring, alternating bit patterns
        queue_code(8191);
        queue_code(0);
        queue_code(1);
        queue_code(8190);
        queue_code(13'h1555);
        queue_code(13'h0AAA);
        // all entries equal at full scale
        for (int i = 0; i < WINDOW_SIZE; i++) queue_code(8191);
        // repeated minimum among maxima
        queue_code(0);
        queue_code(0);
        queue_code(4096);
        queue_code(4095);

        // random segments, some opening with a full drain
        queue_code($urandom_range(0, 8191), 1'b1);
        while (adc_words.size() < 1670) begin
            seg_kind = $urandom_range(0, 3);
            seg_len = $urandom_range(5, 40);
            base = $urandom_range(0, 8191);
            spread = $urandom_range(0, 64);
            step = $urandom_range(1, 600);
            for (int i = 0; i < seg_len; i++) begin
                case (seg_kind)
                    0: queue_code($urandom_range(0, 8191), i == 0 && $urandom_range(0, 14) == 0);
                    1: queue_code(base + $urandom_range(0, 2 * spread) - spread);
                    2: queue_code($urandom_range(0, 1) ? 8191 - $urandom_range(0, spread)
                                                       : $urandom_range(0, spread));
                    default: queue_code((base + i * step) % 8192);
                endcase
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (adc_words.size() != 0 || s_tvalid) @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
